// File: hdl/fbmvn_pkg.sv
// Shared constants and helpers for the fbm value noise pipeline.
`timescale 1ns / 1ps

package fbmvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;

    localparam int COORD_W = 32;
    localparam int FREQ_W  = 32;
    localparam int AMP_W   = 24;
    localparam int PROD_W  = 57;   // n31 (33 signed) times amp (24 unsigned)
    localparam int NOISE_W = 16;
    localparam int QUO_W   = 16;

    localparam int OCT_LAT = 9;
    localparam int DIV_LAT = QUO_W + 2;

    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_PERSIST = 2'd1;
    localparam logic [1:0] CFG_LACUN   = 2'd2;
    localparam logic [1:0] CFG_SEED    = 2'd3;

    localparam logic [3:0]  OCTAVES_RST = 4'd4;
    localparam logic [15:0] PERSIST_RST = 16'd2048;
    localparam logic [15:0] LACUN_RST   = 16'd8192;
    localparam logic [31:0] SEED_RST    = 32'd0;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] FREQ_CAP  = 32'hFFFF_FFFF;
    localparam logic [31:0] AMP_CAP   = 32'h00FF_FFFF;

    localparam logic [31:0] HASH_X    = 32'd1619;
    localparam logic [31:0] HASH_Y    = 32'd31337;
    localparam logic [31:0] HASH_SEED = 32'd6971;
    localparam logic [31:0] HASH_SQ   = 32'd15731;
    localparam logic [31:0] HASH_LIN  = 32'd789221;
    localparam logic [31:0] HASH_ADD  = 32'd1376312589;
    localparam logic [31:0] SEED_STEP = 32'd1973;

    // (v * k + 2048) >> 12, saturated at cap
    function automatic logic [31:0] scale_q12(input logic [31:0] v, input logic [15:0] k,
                                              input logic [31:0] cap);
        logic [48:0] p;
        logic [36:0] r;
        p = 49'(v) * 49'(k) + 49'd2048;
        r = p[48:12];
        scale_q12 = (r > 37'(cap)) ? cap : r[31:0];
    endfunction

endpackage

// File: hdl/fbmvn_octave.sv
// One octave lane: lattice hash, quintic fade, bilinear blend and weighting.
`timescale 1ns / 1ps

module fbmvn_octave
(
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [31:0]                 coord_x,
    input  logic signed [31:0]                 coord_y,
    input  logic [fbmvn_pkg::FREQ_W-1:0]       freq,
    input  logic [fbmvn_pkg::AMP_W-1:0]        amp,
    input  logic [31:0]                        seed_mul,
    input  logic                               active,
    output logic signed [fbmvn_pkg::PROD_W-1:0] weighted
);

    // stage 1: scaled coordinate
    logic signed [64:0] px, py;
    logic [31:0] ix_reg, iy_reg;
    logic [15:0] fx_reg, fy_reg;

    // stage 2: pre-hash and fade square
    logic [31:0] h2_next [4];
    logic [31:0] h2_reg [4];
    logic [31:0] fqx_reg, fqy_reg;
    logic [15:0] fx2_reg, fy2_reg;

    // stage 3
    logic [31:0] hh_reg [4];
    logic [31:0] h3_reg [4];
    logic [31:0] cx_reg, cy_reg;
    logic [20:0] ppx_reg, ppy_reg;

    // stage 4
    logic [31:0] t_reg [4];
    logic [31:0] h4_reg [4];
    logic [16:0] ux4_reg, uy4_reg;

    // stage 5
    logic [31:0] hv [4];
    logic signed [15:0] v_reg [4];
    logic [16:0] ux5_reg, uy5_reg;

    // stages 6 to 9
    logic signed [32:0] top_reg, bot_reg;
    logic [16:0] uy6_reg;
    logic signed [48:0] n_reg;
    logic signed [32:0] n31_reg;
    logic signed [fbmvn_pkg::PROD_W-1:0] w_reg;

    logic [31:0] ax, ay;

    assign px = coord_x * $signed({1'b0, freq});
    assign py = coord_y * $signed({1'b0, freq});

    always_comb
    begin
        ax = ix_reg * fbmvn_pkg::HASH_X;
        ay = iy_reg * fbmvn_pkg::HASH_Y;
        h2_next[0] = (ax + ay) ^ seed_mul;
        h2_next[1] = (ax + fbmvn_pkg::HASH_X + ay) ^ seed_mul;
        h2_next[2] = (ax + ay + fbmvn_pkg::HASH_Y) ^ seed_mul;
        h2_next[3] = (ax + fbmvn_pkg::HASH_X + ay + fbmvn_pkg::HASH_Y) ^ seed_mul;
        for (int i = 0; i < 4; i++)
        begin
            h2_next[i] = h2_next[i] ^ (h2_next[i] >> 13);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            hv[i] = h4_reg[i] * t_reg[i] + fbmvn_pkg::HASH_ADD;
        end
    end

    function automatic logic [20:0] fade_poly(input logic [31:0] q, input logic [15:0] f);
        logic [37:0] p;
        p = (38'd10 << 32) + 38'(q) * 38'd6 - ((38'(f) * 38'd15) << 16);
        fade_poly = p[36:16];
    endfunction

    function automatic logic [16:0] fade_out(input logic [31:0] c, input logic [20:0] pp);
        logic [52:0] prod;
        logic [20:0] u;
        prod = 53'(c) * 53'(pp) + (53'd1 << 31);
        u = prod[52:32];
        fade_out = (u > 21'd65536) ? 17'd65536 : u[16:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix_reg <= px[63:32];
            iy_reg <= py[63:32];
            fx_reg <= px[31:16];
            fy_reg <= py[31:16];

            h2_reg  <= h2_next;
            fqx_reg <= 32'(fx_reg) * 32'(fx_reg);
            fqy_reg <= 32'(fy_reg) * 32'(fy_reg);
            fx2_reg <= fx_reg;
            fy2_reg <= fy_reg;

            for (int i = 0; i < 4; i++)
            begin
                hh_reg[i] <= h2_reg[i] * h2_reg[i];
                h3_reg[i] <= h2_reg[i];
                t_reg[i]  <= hh_reg[i] * fbmvn_pkg::HASH_SQ + fbmvn_pkg::HASH_LIN;
                h4_reg[i] <= h3_reg[i];
                // (h & 0xffff) - 32768 is the low half with its top bit flipped
                v_reg[i]  <= $signed({~hv[i][15], hv[i][14:0]});
            end
            cx_reg  <= 32'((48'(fqx_reg) * 48'(fx2_reg)) >> 16);
            cy_reg  <= 32'((48'(fqy_reg) * 48'(fy2_reg)) >> 16);
            ppx_reg <= fade_poly(fqx_reg, fx2_reg);
            ppy_reg <= fade_poly(fqy_reg, fy2_reg);

            ux4_reg <= fade_out(cx_reg, ppx_reg);
            uy4_reg <= fade_out(cy_reg, ppy_reg);
            ux5_reg <= ux4_reg;
            uy5_reg <= uy4_reg;

            top_reg <= 33'(v_reg[0] * $signed({1'b0, 17'd65536 - ux5_reg}))
                     + 33'(v_reg[1] * $signed({1'b0, ux5_reg}));
            bot_reg <= 33'(v_reg[2] * $signed({1'b0, 17'd65536 - ux5_reg}))
                     + 33'(v_reg[3] * $signed({1'b0, ux5_reg}));
            uy6_reg <= uy5_reg;

            n_reg <= 49'(top_reg * $signed({1'b0, 17'd65536 - uy6_reg}))
                   + 49'(bot_reg * $signed({1'b0, uy6_reg}));

            // arithmetic shift is a floor
            n31_reg <= 33'((n_reg + 49'sd32768) >>> 16);

            w_reg <= active ? fbmvn_pkg::PROD_W'(n31_reg * $signed({1'b0, amp}))
                            : '0;
        end
    end

    assign weighted = w_reg;

endmodule

// File: hdl/fbmvn_div.sv
// Pipelined restoring divider: rounded sum / (total * 2^16), saturated to Q1.15.
`timescale 1ns / 1ps

module fbmvn_div #(
    parameter int SUM_W = 60,
    parameter int TOT_W = 28
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [SUM_W-1:0]             sum_in,
    input  logic [TOT_W-1:0]                    total,
    input  logic                                zero,
    output logic signed [fbmvn_pkg::NOISE_W-1:0] noise
);

    localparam int Q     = fbmvn_pkg::QUO_W;
    localparam int NUM_W = ((SUM_W > TOT_W + 32) ? SUM_W : TOT_W + 32) + 1;

    logic [SUM_W-1:0] mag;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] rem_reg [Q];
    logic [Q-1:0]     q_reg [Q+1];
    logic             sign_reg [Q+1];
    logic             ovf_reg [Q+1];
    logic signed [fbmvn_pkg::NOISE_W-1:0] noise_reg;

    assign mag = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
    assign num = NUM_W'(mag) + (NUM_W'(total) << 15);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            sign_reg[0] <= sum_in[SUM_W-1];
            // quotient would not fit in Q bits
            ovf_reg[0]  <= (num >= (NUM_W'(total) << 32));
        end
    end

    for (genvar j = 0; j < Q; j++)
    begin : g_step
        logic [NUM_W-1:0] dsh;
        logic             take;
        assign dsh  = NUM_W'(total) << (Q - 1 - j + 16);
        assign take = (rem_reg[j] >= dsh);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[j+1]    <= q_reg[j] | (take ? (Q'(1) << (Q - 1 - j)) : '0);
                sign_reg[j+1] <= sign_reg[j];
                ovf_reg[j+1]  <= ovf_reg[j];
            end
        end
        if (j < Q - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= take ? rem_reg[j] - dsh : rem_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero)
            begin
                noise_reg <= '0;
            end
            else if (sign_reg[Q])
            begin
                if (ovf_reg[Q] || ({1'b0, q_reg[Q]} > 17'd32768))
                begin
                    noise_reg <= 16'sh8000;
                end
                else
                begin
                    noise_reg <= $signed(16'(17'd0 - {1'b0, q_reg[Q]}));
                end
            end
            else
            begin
                noise_reg <= (ovf_reg[Q] || q_reg[Q][Q-1]) ? 16'sh7FFF : $signed(q_reg[Q]);
            end
        end
    end

    assign noise = noise_reg;

endmodule

// File: hdl/fbm_value_noise_2d.sv
// Top level of the 2D fbm value noise pipeline with its register file.
//
// Input channel in_valid/in_ready carries one sample point (coord_x, coord_y,
// signed Q16.16) per request; the output channel out_valid/out_ready returns one
// noise_value (signed Q1.15) per point, in order.
// The config channel cfg_valid/cfg_ready writes register cfg_index with cfg_data:
// 0 octave count, 1 persistence Q4.12, 2 lacunarity Q4.12, 3 seed.
// Throughput: one point per cycle unless a stall or table build holds it. There
// are 27 + ceil(log2(MAX_OCTAVES)) register stages, at least one tree level
// (30 by default): 9 stages per octave lane (all octaves run side by side), a
// registered adder tree, and an 18-stage divider (entry, 16 quotient steps,
// saturation). After reset and after every config write the per-octave
// frequency and amplitude tables are rebuilt, one octave per cycle; in_ready
// stays low meanwhile. Reset loads the default register values.
// When out_ready is low with a result pending, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module fbm_value_noise_2d #(
    parameter int MAX_OCTAVES = fbmvn_pkg::MAX_OCTAVES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   coord_x,
    input  logic signed [31:0]   coord_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   noise_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int LEVELS = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int NPAD   = 1 << LEVELS;
    localparam int SUM_W  = fbmvn_pkg::PROD_W + LEVELS;
    localparam int TOT_W  = fbmvn_pkg::AMP_W + $clog2(MAX_OCTAVES + 1);
    localparam int IDX_W  = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int LAT    = fbmvn_pkg::OCT_LAT + LEVELS + fbmvn_pkg::DIV_LAT;

    logic [3:0]  octaves_reg;
    logic [15:0] persist_reg;
    logic [15:0] lacun_reg;
    logic [31:0] seed_reg;

    logic             busy_reg;
    logic [IDX_W-1:0] step_reg;
    logic [31:0]      freq_run_reg;
    logic [31:0]      amp_run_reg;
    logic [TOT_W-1:0] total_reg;
    logic [31:0]      freq_tab_reg [MAX_OCTAVES];
    logic [fbmvn_pkg::AMP_W-1:0] amp_tab_reg [MAX_OCTAVES];
    logic [31:0]      seed_mul_reg [MAX_OCTAVES];

    logic             cfg_we;
    logic             adv;
    logic [LAT-1:0]   vld_reg;

    logic signed [fbmvn_pkg::PROD_W-1:0] lane_w [MAX_OCTAVES];
    logic signed [SUM_W-1:0] leaf [NPAD];
    logic signed [SUM_W-1:0] node_reg [1:NPAD-1];

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign adv       = !vld_reg[LAT-1] || out_ready;
    assign in_ready  = adv && !busy_reg;
    assign out_valid = vld_reg[LAT-1];

    // register file and table builder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octaves_reg  <= fbmvn_pkg::OCTAVES_RST;
            persist_reg  <= fbmvn_pkg::PERSIST_RST;
            lacun_reg    <= fbmvn_pkg::LACUN_RST;
            seed_reg     <= fbmvn_pkg::SEED_RST;
            busy_reg     <= 1'b1;
            step_reg     <= '0;
            freq_run_reg <= fbmvn_pkg::ONE_Q16;
            amp_run_reg  <= fbmvn_pkg::ONE_Q16;
            total_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fbmvn_pkg::CFG_OCTAVES: octaves_reg <= cfg_data[3:0];
                fbmvn_pkg::CFG_PERSIST: persist_reg <= cfg_data[15:0];
                fbmvn_pkg::CFG_LACUN:   lacun_reg   <= cfg_data[15:0];
                default:                seed_reg    <= cfg_data;
            endcase
            busy_reg     <= 1'b1;
            step_reg     <= '0;
            freq_run_reg <= fbmvn_pkg::ONE_Q16;
            amp_run_reg  <= fbmvn_pkg::ONE_Q16;
            total_reg    <= '0;
        end
        else if (busy_reg)
        begin
            freq_run_reg <= fbmvn_pkg::scale_q12(freq_run_reg, lacun_reg, fbmvn_pkg::FREQ_CAP);
            amp_run_reg  <= fbmvn_pkg::scale_q12(amp_run_reg, persist_reg, fbmvn_pkg::AMP_CAP);
            if (32'(step_reg) < 32'(octaves_reg))
            begin
                total_reg <= total_reg + TOT_W'(amp_run_reg);
            end
            if (32'(step_reg) == MAX_OCTAVES - 1)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            freq_tab_reg[step_reg] <= freq_run_reg;
            amp_tab_reg[step_reg]  <= amp_run_reg[fbmvn_pkg::AMP_W-1:0];
        end
        for (int o = 0; o < MAX_OCTAVES; o++)
        begin
            seed_mul_reg[o] <= (seed_reg + 32'(o) * fbmvn_pkg::SEED_STEP)
                               * fbmvn_pkg::HASH_SEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid && in_ready};
        end
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++)
    begin : g_lane
        fbmvn_octave u_octave
        (
            .clk      (clk),
            .en       (adv),
            .coord_x  (coord_x),
            .coord_y  (coord_y),
            .freq     (freq_tab_reg[o]),
            .amp      (amp_tab_reg[o]),
            .seed_mul (seed_mul_reg[o]),
            .active   (32'(octaves_reg) > o),
            .weighted (lane_w[o])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NPAD; i++)
        begin
            leaf[i] = '0;
        end
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            leaf[i] = SUM_W'(lane_w[i]);
        end
    end

    // registered adder tree, heap order: node k sums children 2k and 2k+1
    for (genvar k = 1; k < NPAD; k++)
    begin : g_node
        logic signed [SUM_W-1:0] lhs, rhs;
        if (2 * k >= NPAD)
        begin : g_leafs
            assign lhs = leaf[2 * k - NPAD];
            assign rhs = leaf[2 * k + 1 - NPAD];
        end
        else
        begin : g_inner
            assign lhs = node_reg[2 * k];
            assign rhs = node_reg[2 * k + 1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                node_reg[k] <= lhs + rhs;
            end
        end
    end

    fbmvn_div #(
        .SUM_W (SUM_W),
        .TOT_W (TOT_W)
    ) u_div
    (
        .clk    (clk),
        .en     (adv),
        .sum_in (node_reg[1]),
        .total  (total_reg),
        .zero   (octaves_reg == 4'd0),
        .noise  (noise_value)
    );

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input accepted right after a config write");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline moved during a stall");

    a_build_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !cfg_we && (32'(step_reg) == MAX_OCTAVES - 1) |=> !busy_reg)
        else $error("table build did not finish");

endmodule
